@@ hw/rtl/byte_ring_fifo_assert.svh @@
// assertion macros for the byte ring fifo checker
`ifndef BYTE_RING_FIFO_ASSERT_SVH
`define BYTE_RING_FIFO_ASSERT_SVH

// property checked on every rising clock edge outside reset
`define BRF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// implication checked on every rising clock edge outside reset
`define BRF_ASSERT_IMPL(label, ante, cons, msg) \
   `BRF_ASSERT(label, (ante) |-> (cons), msg)

`endif

@@ hw/rtl/brf_pkg.sv @@
// types and constants shared by the byte ring fifo modules
`default_nettype none

package brf_pkg;

   localparam int CMD_W    = 3;
   localparam int BYTE_W   = 8;
   localparam int AMOUNT_W = 10;
   localparam int COUNT_W  = 10;
   localparam int STATUS_W = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH      = 3'd0,
      CMD_POP       = 3'd1,
      CMD_PEEK      = 3'd2,
      CMD_ADV_WRITE = 3'd3,
      CMD_ADV_READ  = 3'd4,
      CMD_CLEAR     = 3'd5,
      CMD_STATUS    = 3'd6
   } cmd_type;

   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]    command;
      logic [BYTE_W-1:0]   write_byte;
      logic [AMOUNT_W-1:0] amount;
   } req_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   read_byte;
      logic [COUNT_W-1:0]  used_count;
      logic [COUNT_W-1:0]  free_count;
      logic [COUNT_W-1:0]  write_run;
      logic [COUNT_W-1:0]  read_run;
   } rsp_item_type;

   // result fields known at the end of the command stage
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  used_count;
      logic [COUNT_W-1:0]  free_count;
      logic [COUNT_W-1:0]  write_run;
      logic [COUNT_W-1:0]  read_run;
   } res_info_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_op_type;

endpackage

`default_nettype wire

@@ hw/rtl/brf_ram.sv @@
// generic single write port ram with one registered read port
`default_nettype none

module brf_ram #(
   parameter  int WIDTH  = 8,
   parameter  int DEPTH  = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/brf_ctrl.sv @@
// command decode, index update and count logic of the byte ring fifo
`default_nettype none

module brf_ctrl #(
   parameter  int CAPACITY = 1023,
   localparam int SLOTS    = CAPACITY + 1,
   localparam int IDX_W    = $clog2(SLOTS)
) (
   input  logic [brf_pkg::CMD_W-1:0]    command,
   input  logic [brf_pkg::AMOUNT_W-1:0] amount,
   input  logic [brf_pkg::AMOUNT_W-1:0] quot,
   input  logic [IDX_W-1:0]             wr_idx,
   input  logic [IDX_W-1:0]             rd_idx,
   output logic [IDX_W-1:0]             wr_next,
   output logic [IDX_W-1:0]             rd_next,
   output logic [IDX_W-1:0]             rd_addr,
   output brf_pkg::mem_op_type          mem_op,
   output brf_pkg::res_info_type        info
);

   import brf_pkg::*;

   localparam int SUM_W = ((IDX_W > AMOUNT_W) ? IDX_W : AMOUNT_W) + 1;
   localparam logic [SUM_W-1:0] SLOTS_S = SUM_W'(SLOTS);
   localparam logic [SUM_W-1:0] CAP_S   = SUM_W'(CAPACITY);
   localparam logic [SUM_W-1:0] ONE_S   = SUM_W'(1);

   function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] idx,
                                                 input logic [SUM_W-1:0] n);
      logic [SUM_W-1:0] s;
      s = SUM_W'(idx) + n;
      if (s >= SLOTS_S) begin
         s = s - SLOTS_S;
      end
      return IDX_W'(s);
   endfunction

   function automatic logic [SUM_W-1:0] used_of(input logic [IDX_W-1:0] w,
                                                input logic [IDX_W-1:0] r);
      if (w >= r) begin
         return SUM_W'(w) - SUM_W'(r);
      end
      return SUM_W'(w) + SLOTS_S - SUM_W'(r);
   endfunction

   logic [AMOUNT_W-1:0] quot_slots;
   logic [SUM_W-1:0]    amt_red;
   logic [IDX_W-1:0]    wr_inc;
   logic [IDX_W-1:0]    rd_inc;
   logic [SUM_W-1:0]    used_now;
   logic [SUM_W-1:0]    used_next;
   logic [SUM_W-1:0]    wr_room;
   logic [SUM_W-1:0]    rd_room;
   logic [STATUS_W-1:0] status;

   // amount modulo slot count, quotient comes from the input stage
   assign quot_slots = AMOUNT_W'(32'(quot) * 32'(SLOTS));
   assign amt_red    = SUM_W'(amount - quot_slots);

   assign wr_inc   = wrap_add(wr_idx, ONE_S);
   assign rd_inc   = wrap_add(rd_idx, ONE_S);
   assign used_now = used_of(wr_idx, rd_idx);

   always_comb begin
      wr_next       = wr_idx;
      rd_next       = rd_idx;
      rd_addr       = rd_idx;
      mem_op.wr_en  = 1'b0;
      mem_op.rd_en  = 1'b0;
      status        = STATUS_DONE;
      case (command)
         CMD_PUSH: begin
            if (wr_inc == rd_idx) begin
               status = STATUS_FULL;
            end else begin
               mem_op.wr_en = 1'b1;
               wr_next      = wr_inc;
            end
         end
         CMD_POP: begin
            if (wr_idx == rd_idx) begin
               status = STATUS_EMPTY;
            end else begin
               mem_op.rd_en = 1'b1;
               rd_next      = rd_inc;
            end
         end
         CMD_PEEK: begin
            if (SUM_W'(amount) >= used_now) begin
               status = STATUS_EMPTY;
            end else begin
               mem_op.rd_en = 1'b1;
               rd_addr      = wrap_add(rd_idx, amt_red);
            end
         end
         CMD_ADV_WRITE: wr_next = wrap_add(wr_idx, amt_red);
         CMD_ADV_READ:  rd_next = wrap_add(rd_idx, amt_red);
         CMD_CLEAR: begin
            wr_next = '0;
            rd_next = '0;
         end
         default: ;
      endcase
   end

   assign used_next = used_of(wr_next, rd_next);

   always_comb begin
      if (rd_next > wr_next) begin
         wr_room = SUM_W'(rd_next) - SUM_W'(wr_next) - ONE_S;
         rd_room = SLOTS_S - SUM_W'(rd_next);
      end else begin
         rd_room = SUM_W'(wr_next) - SUM_W'(rd_next);
         if (rd_next == '0) begin
            wr_room = SLOTS_S - SUM_W'(wr_next) - ONE_S;
         end else begin
            wr_room = SLOTS_S - SUM_W'(wr_next);
         end
      end
   end

   assign info.status     = status;
   assign info.used_count = used_next[COUNT_W-1:0];
   assign info.free_count = COUNT_W'(CAP_S - used_next);
   assign info.write_run  = wr_room[COUNT_W-1:0];
   assign info.read_run   = rd_room[COUNT_W-1:0];

endmodule

`default_nettype wire

@@ hw/rtl/byte_ring_fifo.sv @@
// top level of the byte ring fifo: input stage, command stage, result register
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_ready | req_item: command, write_byte, amount
//   rsp     | out       | rsp_valid/rsp_ready | rsp_item: status, read_byte, counts, runs
//
// one item per cycle sustained while rsp is not stalled; a req passes the input stage, then the result register
// the command stage reads and updates both indices together, so the ring
// state seen by an item is the one left by the item before it
// byte storage is one ram with a write port and a registered read port
// reset zeroes both indices and empties the pipeline; storage is not cleared
// a stalled rsp holds the command stage, which in turn holds req_ready low
`default_nettype none

module byte_ring_fifo #(
   parameter int CAPACITY = 1023
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  brf_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output brf_pkg::rsp_item_type rsp_item
);

   import brf_pkg::*;

   localparam int SLOTS   = CAPACITY + 1;
   localparam int IDX_W   = $clog2(SLOTS);
   localparam int SHIFT   = AMOUNT_W + IDX_W;
   localparam int RECIP_W = AMOUNT_W + 2;
   localparam int PROD_W  = AMOUNT_W + RECIP_W;
   // rounded-up reciprocal, exact floor division for every 10-bit amount
   localparam longint RECIP_L =
      ((longint'(1) << SHIFT) + longint'(SLOTS) - 1) / longint'(SLOTS);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

   // input stage
   logic                s1_valid_ff;
   logic                s1_valid_in;
   req_item_type        s1_item_ff;
   req_item_type        s1_item_in;
   logic [AMOUNT_W-1:0] s1_quot_ff;
   logic [AMOUNT_W-1:0] s1_quot_in;
   logic [PROD_W-1:0]   recip_prod;

   // ring indices
   logic [IDX_W-1:0] wr_idx_ff;
   logic [IDX_W-1:0] wr_idx_in;
   logic [IDX_W-1:0] rd_idx_ff;
   logic [IDX_W-1:0] rd_idx_in;

   // result register
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   res_info_type rsp_info_ff;
   res_info_type rsp_info_in;
   logic         rd_sel_ff;
   logic         rd_sel_in;

   // command stage outputs
   logic [IDX_W-1:0]  wr_next;
   logic [IDX_W-1:0]  rd_next;
   logic [IDX_W-1:0]  rd_addr;
   mem_op_type        mem_op;
   res_info_type      info;
   logic [BYTE_W-1:0] ram_rd_data;

   logic advance;
   logic fire;

   // result register free or being emptied this cycle
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign fire      = s1_valid_ff && advance;
   assign req_ready = !s1_valid_ff || advance;

   // quotient of amount by slot count, so the command stage only subtracts
   assign recip_prod = PROD_W'(req_item.amount) * PROD_W'(RECIP);

   always_comb begin
      s1_valid_in = req_ready ? req_valid : s1_valid_ff;
      s1_item_in  = s1_item_ff;
      s1_quot_in  = s1_quot_ff;
      if (req_valid && req_ready) begin
         s1_item_in = req_item;
         s1_quot_in = AMOUNT_W'(recip_prod >> SHIFT);
      end
   end

   brf_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .command (s1_item_ff.command),
      .amount  (s1_item_ff.amount),
      .quot    (s1_quot_ff),
      .wr_idx  (wr_idx_ff),
      .rd_idx  (rd_idx_ff),
      .wr_next (wr_next),
      .rd_next (rd_next),
      .rd_addr (rd_addr),
      .mem_op  (mem_op),
      .info    (info)
   );

   brf_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (SLOTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (fire && mem_op.wr_en),
      .wr_addr (wr_idx_ff),
      .wr_data (s1_item_ff.write_byte),
      .rd_en   (fire && mem_op.rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   // indices and result fields move only when the command stage hands over its item; result valid follows each advance
   always_comb begin
      wr_idx_in    = fire ? wr_next : wr_idx_ff;
      rd_idx_in    = fire ? rd_next : rd_idx_ff;
      rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;
      rsp_info_in  = fire ? info : rsp_info_ff;
      rd_sel_in    = fire ? mem_op.rd_en : rd_sel_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         wr_idx_ff    <= '0;
         rd_idx_ff    <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         wr_idx_ff    <= wr_idx_in;
         rd_idx_ff    <= rd_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff  <= s1_item_in;
      s1_quot_ff  <= s1_quot_in;
      rsp_info_ff <= rsp_info_in;
      rd_sel_ff   <= rd_sel_in;
   end

   // ram read data lands together with the result register and holds while stalled
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_item.status     = rsp_info_ff.status;
   assign rsp_item.read_byte  = rd_sel_ff ? ram_rd_data : '0;
   assign rsp_item.used_count = rsp_info_ff.used_count;
   assign rsp_item.free_count = rsp_info_ff.free_count;
   assign rsp_item.write_run  = rsp_info_ff.write_run;
   assign rsp_item.read_run   = rsp_info_ff.read_run;

endmodule

`default_nettype wire

@@ hw/rtl/brf_checker.sv @@
// port checker for the byte ring fifo and its bind
`default_nettype none

`include "byte_ring_fifo_assert.svh"

module brf_checker #(
   parameter int CAPACITY = 1023
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input brf_pkg::req_item_type req_item,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input brf_pkg::rsp_item_type rsp_item
);

   import brf_pkg::*;

   localparam logic [COUNT_W-1:0] CAP_C = COUNT_W'(CAPACITY);

   logic [COUNT_W-1:0] count_sum;

   assign count_sum = rsp_item.used_count + rsp_item.free_count;

   `BRF_ASSERT(rsp_hold_a, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item), "rsp item changed while stalled")
   `BRF_ASSERT_IMPL(count_sum_a, rsp_valid, count_sum == CAP_C, "used plus free differs from capacity")
   `BRF_ASSERT_IMPL(full_a, rsp_valid && rsp_item.status == STATUS_FULL, rsp_item.free_count == '0 && rsp_item.read_byte == '0, "refused push with room left")
   `BRF_ASSERT_IMPL(empty_a, rsp_valid && rsp_item.status == STATUS_EMPTY, rsp_item.read_byte == '0, "failed read returned data")

endmodule

bind byte_ring_fifo brf_checker #(.CAPACITY(CAPACITY)) u_checker (.*);

`default_nettype wire

@@ dv/byte_ring_fifo_tb.sv @@
// testbench for the byte ring fifo: paced command traffic checked against a ring model
module byte_ring_fifo_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import brf_pkg::*;

   localparam int CAPACITY     = 1023;
   localparam int SLOTS        = CAPACITY + 1;
   localparam int RESET_CYCLES = 12;
   localparam int RANDOM_ITEMS = 1680;
   // cycles with no item moving on either channel before the run is abandoned
   localparam int STALL_LIMIT  = 2000;
   // quiet cycles after the last result, to catch anything extra
   localparam int TAIL_CYCLES  = 10;
   // the one command code with no meaning, answered like a status query
   localparam logic [CMD_W-1:0] CMD_RESERVED = 3'd7;

   // receiver behaviour, changed at the end of each randomly long phase
   typedef enum {
      READY_ALWAYS,
      READY_MOSTLY,
      READY_SELDOM,
      READY_PULSED
   } ready_pattern_type;

   // one planned command and the answer the ring model gives for it
   typedef struct {
      req_item_type cmd;
      rsp_item_type answer;
   } ring_op_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_item_type req_item  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_item_type rsp_item;

   // ring model: storage, which slots have ever been written, both indices
   logic [BYTE_W-1:0] ring_bytes [SLOTS];
   bit                ring_written [SLOTS];
   int                wr_idx = 0;
   int                rd_idx = 0;

   ring_op_type  pending_ops [$];      // commands not yet offered to the block
   rsp_item_type awaited_answers [$];  // answers for accepted commands, oldest first
   rsp_item_type bus_answer;           // answer for the item now on the req bus
   int           sent_count  = 0;      // items put on the req bus
   int           taken_count = 0;      // items accepted by the block
   int           error_count = 0;
   int           idle_cycles = 0;

   // sender pacing
   int burst_left = 0;
   int gap_left   = 0;

   // receiver pacing
   ready_pattern_type ready_mode = READY_ALWAYS;
   int                ready_phase = 0;

   // command mix in percent, indexed by command code
   // rows: filling, draining, balanced, index games
   int unsigned mix [4][8] = '{
      '{55, 15, 15,  4,  4, 2, 3, 2},
      '{20, 45, 20,  4,  4, 2, 3, 2},
      '{35, 30, 20,  4,  4, 2, 3, 2},
      '{25, 20, 10, 15, 15, 5, 6, 4}};

   byte_ring_fifo #(
      .CAPACITY (CAPACITY)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   always #2 clock = ~clock;

   // bytes held, with one slot always left empty
   function automatic int ring_used();
      return (wr_idx + SLOTS - rd_idx) % SLOTS;
   endfunction

   // applies one command to the ring model and returns the block's answer
   function automatic rsp_item_type ring_execute(req_item_type op);
      rsp_item_type res;
      int           held;
      int           wroom;
      int           rroom;
      res = '0;
      res.status = STATUS_DONE;
      case (op.command)
         CMD_PUSH: begin
            if ((wr_idx + 1) % SLOTS == rd_idx) begin
               res.status = STATUS_FULL;
            end else begin
               ring_bytes[wr_idx]   = op.write_byte;
               ring_written[wr_idx] = 1'b1;
               wr_idx = (wr_idx + 1) % SLOTS;
            end
         end
         CMD_POP: begin
            if (wr_idx == rd_idx) begin
               res.status = STATUS_EMPTY;
            end else begin
               res.read_byte = ring_bytes[rd_idx];
               rd_idx = (rd_idx + 1) % SLOTS;
            end
         end
         CMD_PEEK: begin
            if (int'(op.amount) >= ring_used()) begin
               res.status = STATUS_EMPTY;
            end else begin
               res.read_byte = ring_bytes[(rd_idx + int'(op.amount)) % SLOTS];
            end
         end
         // index moves are unchecked against the other index
         CMD_ADV_WRITE: wr_idx = (wr_idx + int'(op.amount)) % SLOTS;
         CMD_ADV_READ:  rd_idx = (rd_idx + int'(op.amount)) % SLOTS;
         CMD_CLEAR: begin
            wr_idx = 0;
            rd_idx = 0;
         end
         // status query and the reserved code leave the ring alone
         default: ;
      endcase
      held = ring_used();
      // contiguous room up to the wrap, as for direct enqueue and dequeue
      if (rd_idx > wr_idx) begin
         wroom = rd_idx - wr_idx - 1;
      end else if (rd_idx == 0) begin
         wroom = SLOTS - wr_idx - 1;
      end else begin
         wroom = SLOTS - wr_idx;
      end
      if (rd_idx > wr_idx) begin
         rroom = SLOTS - rd_idx;
      end else begin
         rroom = wr_idx - rd_idx;
      end
      res.used_count = COUNT_W'(held);
      res.free_count = COUNT_W'(CAPACITY - held);
      res.write_run  = COUNT_W'(wroom);
      res.read_run   = COUNT_W'(rroom);
      return res;
   endfunction

   // offset or index step: mostly small, sometimes the edges of the ring
   function automatic logic [AMOUNT_W-1:0] pick_amount(logic [CMD_W-1:0] code);
      int held;
      held = ring_used();
      case ($urandom_range(9, 0))
         0:       return '1;
         1, 2:    return AMOUNT_W'($urandom);
         // write step to exactly full, read step to exactly empty,
         // peek one past the last held byte
         3:       return (code == CMD_ADV_WRITE) ? AMOUNT_W'(CAPACITY - held)
                                                 : AMOUNT_W'(held);
         default: return (code == CMD_PEEK) ? AMOUNT_W'($urandom_range(held, 0))
                                            : AMOUNT_W'($urandom_range(8, 0));
      endcase
   endfunction

   // queues one command with its answer, never reading a slot that was
   // never written since reset
   task automatic plan_command(logic [CMD_W-1:0] code, logic [BYTE_W-1:0] data,
                               logic [AMOUNT_W-1:0] amount);
      ring_op_type op;
      int          held;
      held = ring_used();
      // front byte never stored: step over it rather than pop it
      if (code == CMD_POP && held != 0 && !ring_written[rd_idx]) begin
         code   = CMD_ADV_READ;
         amount = AMOUNT_W'(1);
      end
      // same for a peek: push the offset past the held data
      if (code == CMD_PEEK && int'(amount) < held &&
          !ring_written[(rd_idx + int'(amount)) % SLOTS]) begin
         amount = AMOUNT_W'($urandom_range(CAPACITY, held));
      end
      op.cmd.command    = code;
      op.cmd.write_byte = data;
      op.cmd.amount     = amount;
      op.answer         = ring_execute(op.cmd);
      pending_ops.push_back(op);
   endtask

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // whole command stream is planned up front, then reset is released
   initial begin : stimulus
      int mode;
      int code;
      int roll;
      int planned;

      // reset state, empty ring refusals, meaningless code
      plan_command(CMD_STATUS,   8'hFF, '1);
      plan_command(CMD_POP,      8'h00, '0);
      plan_command(CMD_PEEK,     8'h00, '0);
      plan_command(CMD_RESERVED, 8'hFF, '1);
      // a few bytes, then peeks inside and just outside the data
      plan_command(CMD_PUSH,     8'h00, '0);
      plan_command(CMD_PUSH,     8'hFF, '1);
      plan_command(CMD_PUSH,     8'hA5, '0);
      plan_command(CMD_PEEK,     8'h00, '0);
      plan_command(CMD_PEEK,     8'h00, AMOUNT_W'(2));
      plan_command(CMD_PEEK,     8'h00, AMOUNT_W'(3));
      plan_command(CMD_PEEK,     8'h00, '1);
      // drain, then one pop too many
      plan_command(CMD_POP,      8'h00, '0);
      plan_command(CMD_POP,      8'h00, '0);
      plan_command(CMD_POP,      8'h00, '0);
      plan_command(CMD_POP,      8'h00, '0);
      // zero steps change nothing
      plan_command(CMD_ADV_WRITE, 8'h00, '0);
      plan_command(CMD_ADV_READ,  8'h00, '0);
      plan_command(CMD_CLEAR,     8'h00, '0);
      // full ring by index move, refused push, empty again at the top slot
      plan_command(CMD_ADV_WRITE, 8'h00, '1);
      plan_command(CMD_PUSH,      8'h3C, '0);
      plan_command(CMD_ADV_READ,  8'h00, '1);
      // push into the top slot wraps the write index
      plan_command(CMD_PUSH,      8'h5A, '0);
      plan_command(CMD_PEEK,      8'h00, '0);
      plan_command(CMD_POP,       8'h00, '0);
      plan_command(CMD_CLEAR,     8'hFF, '1);

      // random traffic in segments, each with its own command mix
      planned = 0;
      while (planned < RANDOM_ITEMS) begin
         mode = $urandom_range(3, 0);
         repeat ($urandom_range(80, 10)) begin
            roll = $urandom_range(99, 0);
            code = 0;
            while (roll >= mix[mode][code]) begin
               roll -= mix[mode][code];
               code++;
            end
            plan_command(CMD_W'(code), BYTE_W'($urandom), pick_amount(CMD_W'(code)));
            planned++;
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // wait for every command to go in and every answer to come back
      while (pending_ops.size() != 0 || req_valid || awaited_answers.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // sender: bursts of items with random gaps, valid held until taken
   always @(negedge clock) begin : driver
      ring_op_type op;
      if (!reset) begin
         // bus idle or its item already taken
         if (taken_count == sent_count) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_ops.size() != 0) begin
               op = pending_ops.pop_front();
               bus_answer = op.answer;
               req_item  <= op.cmd;
               req_valid <= 1'b1;
               sent_count++;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  // new burst; about a quarter follow on with no gap at all
                  burst_left = $urandom_range(40, 0);
                  gap_left   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: stall pattern switched at the end of each randomly long phase
   always @(negedge clock) begin : receiver
      if (ready_phase == 0) begin
         ready_mode  = ready_pattern_type'($urandom_range(3, 0));
         ready_phase = $urandom_range(64, 16);
      end
      ready_phase--;
      case (ready_mode)
         READY_ALWAYS: rsp_ready <= 1'b1;
         READY_MOSTLY: rsp_ready <= ($urandom_range(3, 0) != 0);
         READY_SELDOM: rsp_ready <= ($urandom_range(3, 0) == 0);
         default:      rsp_ready <= (ready_phase % 8 == 0);
      endcase
   end

   // both channels sampled at the rising edge
   always @(posedge clock) begin : monitor
      rsp_item_type want;
      if (!reset) begin
         // item taken: its answer joins the back of the line
         if (req_valid && req_ready) begin
            awaited_answers.push_back(bus_answer);
            taken_count++;
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_answers.size() == 0) begin
               $error("result item with no command outstanding");
               error_count++;
            end else begin
               want = awaited_answers.pop_front();
               check_field("status",     want.status,     rsp_item.status);
               check_field("read_byte",  want.read_byte,  rsp_item.read_byte);
               check_field("used_count", want.used_count, rsp_item.used_count);
               check_field("free_count", want.free_count, rsp_item.free_count);
               check_field("write_run",  want.write_run,  rsp_item.write_run);
               check_field("read_run",   want.read_run,   rsp_item.read_run);
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
   end

   // nothing moving for too long means the block has hung
   initial begin : watchdog
      wait (idle_cycles >= STALL_LIMIT);
      $error("no item moved for %0d cycles", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
   end

endmodule
